// ===== src/bmpw_pkg.sv =====
`default_nettype none

package bmpw_pkg;

  // Register and field widths
  localparam int unsigned SideW   = 15;
  localparam int unsigned CmpW    = SideW + 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned WordSelW = IdxW - 2;
  localparam int unsigned CfgIdxW = 1;

  localparam int unsigned MaxSideDefault = 16384;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 1'b1;

  // File format constants
  localparam int unsigned FileHdrBytes = 14;
  localparam int unsigned InfoHdrBytes = 40;
  localparam int unsigned DataOffset   = FileHdrBytes + InfoHdrBytes;
  localparam int unsigned BitsPerPixel = 24;
  localparam int unsigned ColourPlanes = 1;
  localparam logic [ByteW-1:0] CharB = 8'h42;
  localparam logic [ByteW-1:0] CharM = 8'h4D;

  // Byte positions within one transaction's run
  localparam logic [IdxW-1:0] FirstWordIdx = 6'd2;
  localparam logic [IdxW-1:0] BlueIdx      = 6'd54;
  localparam logic [IdxW-1:0] GreenIdx     = 6'd55;
  localparam logic [IdxW-1:0] RedIdx       = 6'd56;

  // 32-bit header words, counted from the file size word
  localparam logic [WordSelW-1:0] WordSize      = 4'd0;
  localparam logic [WordSelW-1:0] WordOffset    = 4'd2;
  localparam logic [WordSelW-1:0] WordInfo      = 4'd3;
  localparam logic [WordSelW-1:0] WordWidth     = 4'd4;
  localparam logic [WordSelW-1:0] WordHeight    = 4'd5;
  localparam logic [WordSelW-1:0] WordPlanesBpp = 4'd6;

  typedef struct packed {
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [ByteW-1:0] file_byte;
    logic             last_of_run;
    logic             end_of_image;
  } file_out_t;

  typedef struct packed {
    logic [31:0]      file_size;
    logic [SideW-1:0] width;
    logic [SideW-1:0] height;
  } hdr_fields_t;

endpackage

`default_nettype wire

// ===== src/bmpw_byte_mux.sv =====
`default_nettype none

module bmpw_byte_mux (
  input  wire logic [bmpw_pkg::IdxW-1:0]   idx_i,
  input  wire bmpw_pkg::pixel_t            pix_i,
  input  wire bmpw_pkg::hdr_fields_t       hdr_i,
  output logic [bmpw_pkg::ByteW-1:0]       file_byte_o
);

  logic [bmpw_pkg::IdxW-1:0]     rel;
  logic [bmpw_pkg::WordSelW-1:0] word_sel;
  logic [1:0]                    lane;
  logic [31:0]                   word;

  assign rel      = idx_i - bmpw_pkg::FirstWordIdx;
  assign word_sel = rel[bmpw_pkg::IdxW-1:2];
  assign lane     = rel[1:0];

  always_comb begin
    case (word_sel)
      bmpw_pkg::WordSize:      word = hdr_i.file_size;
      bmpw_pkg::WordOffset:    word = 32'(bmpw_pkg::DataOffset);
      bmpw_pkg::WordInfo:      word = 32'(bmpw_pkg::InfoHdrBytes);
      bmpw_pkg::WordWidth:     word = 32'(hdr_i.width);
      bmpw_pkg::WordHeight:    word = 32'(hdr_i.height);
      bmpw_pkg::WordPlanesBpp: word = {16'(bmpw_pkg::BitsPerPixel),
                                       16'(bmpw_pkg::ColourPlanes)};
      default:                 word = '0;
    endcase
  end

  always_comb begin
    if (idx_i < bmpw_pkg::FirstWordIdx) begin
      file_byte_o = idx_i[0] ? bmpw_pkg::CharM : bmpw_pkg::CharB;
    end else if (idx_i < bmpw_pkg::BlueIdx) begin
      // little-endian: lane 0 is the low byte
      file_byte_o = 8'(word >> {lane, 3'b000});
    end else if (idx_i == bmpw_pkg::BlueIdx) begin
      file_byte_o = pix_i.blue;
    end else if (idx_i == bmpw_pkg::GreenIdx) begin
      file_byte_o = pix_i.green;
    end else if (idx_i == bmpw_pkg::RedIdx) begin
      file_byte_o = pix_i.red;
    end else begin
      file_byte_o = '0;
    end
  end

endmodule

`default_nettype wire

// ===== src/bmp_24bit_stream_writer.sv =====
// Streams an uncompressed 24-bit BMP file, one byte per output transaction.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one pixel per
// transaction in file order: bottom row first, left to right in a row.
// Output channel (out_valid_o/out_ready_i/out_data_o) gives file bytes with
// last_of_run on the final byte of a pixel's run, after any pad bytes, and
// end_of_image on the final byte of the file. The first pixel of an image
// is preceded by the 54-byte header; each pixel gives blue, green, red; a
// row end adds 0 to 3 zero pad bytes. Width and height are to be written
// through cfg_we_i/cfg_index_i/cfg_data_i while the block is idle, which
// it does not enforce; 0 reads as 1, values above MAX_SIDE as MAX_SIDE.
// When the block is empty, a pixel passes the input register and then the
// byte sequencer before its first byte appears. Throughput is set by the
// single byte port: three bytes per pixel, plus 54 for a header and 0..3
// for padding. One pixel waits in an input register while the previous one
// drains, so one pixel is taken even while the receiver stalls; a stall
// simply holds the current byte. Reset clears the pixel position and sets
// width and height to 1; the next pixel then starts a new file.
`default_nettype none

module bmp_24bit_stream_writer #(
  parameter int unsigned MAX_SIDE = bmpw_pkg::MaxSideDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire bmpw_pkg::pixel_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output bmpw_pkg::file_out_t                out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [bmpw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bmpw_pkg::SideW-1:0]    cfg_data_i
);

  localparam int unsigned CntW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned CmpW = bmpw_pkg::CmpW;
  localparam int unsigned SideW = bmpw_pkg::SideW;
  localparam int unsigned IdxW = bmpw_pkg::IdxW;

  // configuration
  logic [SideW-1:0] width_q, height_q;
  logic [SideW-1:0] width_c, height_c;
  logic [CmpW-1:0]  row_bytes, padded_bytes;
  logic [1:0]       pad;
  logic [31:0]      prod_q;
  bmpw_pkg::hdr_fields_t hdr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SideW'(1);
      height_q <= SideW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bmpw_pkg::CfgImageWidth:  width_q  <= cfg_data_i;
        bmpw_pkg::CfgImageHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      width_c = SideW'(1);
    end else if (CmpW'(width_q) > CmpW'(MAX_SIDE)) begin
      width_c = SideW'(MAX_SIDE);
    end else begin
      width_c = width_q;
    end
    if (height_q == '0) begin
      height_c = SideW'(1);
    end else if (CmpW'(height_q) > CmpW'(MAX_SIDE)) begin
      height_c = SideW'(MAX_SIDE);
    end else begin
      height_c = height_q;
    end
  end

  assign row_bytes    = (CmpW'(width_c) << 1) + CmpW'(width_c);
  assign padded_bytes = (row_bytes + CmpW'(3)) & ~CmpW'(3);
  assign pad          = 2'(padded_bytes - row_bytes);

  // image payload size, held ready long before any header reaches it
  always_ff @(posedge clk_i) begin
    prod_q <= 32'(padded_bytes) * 32'(height_c);
  end

  assign hdr.file_size = prod_q + 32'(bmpw_pkg::DataOffset);
  assign hdr.width     = width_c;
  assign hdr.height    = height_c;

  // pixel position, advanced on each input transaction
  logic [CntW-1:0] col_q, row_q;
  logic            in_fire, row_end, image_end, hdr_first;

  assign in_fire   = in_valid_i && in_ready_o;
  assign hdr_first = (col_q == '0) && (row_q == '0);
  assign row_end   = (CmpW'(col_q) + CmpW'(1)) >= CmpW'(width_c);
  assign image_end = row_end && ((CmpW'(row_q) + CmpW'(1)) >= CmpW'(height_c));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= image_end ? '0 : row_q + CntW'(1);
      end else begin
        col_q <= col_q + CntW'(1);
      end
    end
  end

  // input register
  logic             s1_valid_q;
  bmpw_pkg::pixel_t s1_pix_q;
  logic             s1_hdr_q, s1_eoi_q;
  logic [1:0]       s1_pad_q;
  logic             load;

  assign in_ready_o = !s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q <= in_data_i;
      s1_hdr_q <= hdr_first;
      s1_eoi_q <= image_end;
      s1_pad_q <= row_end ? pad : 2'd0;
    end
  end

  // byte sequencer
  logic             s2_valid_q;
  bmpw_pkg::pixel_t s2_pix_q;
  logic             s2_eoi_q;
  logic [IdxW-1:0]  idx_q, last_idx_q;
  logic             is_last, out_fire;
  logic [bmpw_pkg::ByteW-1:0] file_byte;

  assign is_last  = idx_q == last_idx_q;
  assign out_fire = out_valid_o && out_ready_i;
  assign load     = s1_valid_q && (!s2_valid_q || (out_fire && is_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (load) begin
      s2_valid_q <= 1'b1;
    end else if (out_fire && is_last) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s2_pix_q   <= s1_pix_q;
      s2_eoi_q   <= s1_eoi_q;
      idx_q      <= s1_hdr_q ? '0 : bmpw_pkg::BlueIdx;
      last_idx_q <= bmpw_pkg::RedIdx + IdxW'(s1_pad_q);
    end else if (out_fire) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  bmpw_byte_mux u_byte_mux (
    .idx_i       (idx_q),
    .pix_i       (s2_pix_q),
    .hdr_i       (hdr),
    .file_byte_o (file_byte)
  );

  assign out_valid_o             = s2_valid_q;
  assign out_data_o.file_byte    = file_byte;
  assign out_data_o.last_of_run  = is_last;
  assign out_data_o.end_of_image = is_last && s2_eoi_q;

endmodule

`default_nettype wire

// ===== src/bmpw_checker.sv =====
`default_nettype none

module bmpw_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire bmpw_pkg::file_out_t out_data_o
);

  // a file ends only on the final byte of a pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_image |-> out_data_o.last_of_run)
    else $error("end_of_image without last_of_run");

  // a stalled byte holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // the byte after a file's end opens the next header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.end_of_image
    |=> !out_valid_o || out_data_o.file_byte == bmpw_pkg::CharB)
    else $error("new file does not start with header");

  // an empty block shows output once a transaction passes the input register and the byte sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |-> ##2 out_valid_o)
    else $error("output did not appear after input");

endmodule

bind bmp_24bit_stream_writer bmpw_checker u_bmpw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
